### design/bfwalk_pkg.sv
`timescale 1ns / 1ps
package bfwalk_pkg;

  // Default sizes of the core.
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_EDGES_DEF  = 256;
  localparam int DIST_WIDTH_DEF = 32;

  // Fixed field widths of the stream words.
  localparam int NODE_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;
  localparam int COUNT_W  = 7;
  localparam int WALK_W   = 33;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Walk weight limits.
  localparam logic signed [WALK_W-1:0] WALK_MAX = 33'sh0FFFFFFFF;
  localparam logic signed [WALK_W-1:0] WALK_MIN = 33'sh100000000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_RD_EDGE,
    ST_RD_B,
    ST_RD_A,
    ST_UPD_A,
    ST_UPD_B,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_WAIT
  } state_t;

endpackage

### design/min_walk_through_node_bellman_ford_core.sv
`timescale 1ns / 1ps
// Edges are taken one per cycle while idle; the word with tlast starts the solve.
// Each edge visit steps through an edge store read, two node reads and two node writes
// on the node memory; a solve runs n-1 relaxation rounds, then max(n,E) marking rounds.
// Results then leave one node at a time, each read only after the previous one is taken.
// Synchronous reset sets node_count to 64 and empties the edge store and node state;
// node state is cleared again after the last result of each graph.
module min_walk_through_node_bellman_ford_core import bfwalk_pkg::*; #(
  parameter int MAX_NODES  = MAX_NODES_DEF,
  parameter int MAX_EDGES  = MAX_EDGES_DEF,
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_W-1:0]     cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // src_node[5:0], dst_node[11:6], edge_weight[27:12], zero fill [31:28]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // node_index[5:0], walk_weight[38:6], zero fill [39]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // unbounded_below[0]
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int DW  = DIST_WIDTH;
  localparam int EW  = 2 * DW + 2;
  localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int RMAX = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int RW  = $clog2(RMAX + 1);
  localparam int SW  = DW + 1;
  localparam int SXW = (SW > WALK_W) ? SW : WALK_W;
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  state_t state, state_next;

  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] n_reg;
  logic [ECW-1:0]     edge_total;
  logic [ECW-1:0]     eidx;
  logic [RW-1:0]      round;
  logic               phase2;
  logic [COUNT_W-1:0] kidx;

  // Edge store.
  logic [EDGE_W-1:0] estore [MAX_EDGES];
  logic [EDGE_W-1:0] edge_q;

  // Node memory signals.
  logic [AW-1:0] d_rd_addr, d_wr_addr;
  logic [EW-1:0] d_rd_data, d_wr_data;
  logic          d_wr_en, d_clr;

  // Current edge and node entries.
  logic [AW-1:0]       ea_node, eb_node;
  logic [WEIGHT_W-1:0] ew;
  logic [EW-1:0]       ent_b;
  logic                same_node;
  logic                newf_p, newb_p;
  logic [DW-1:0]       newf_d, newb_d;
  logic                newb_p_q;
  logic [DW-1:0]       newb_d_q;
  logic                newf_p_q;
  logic [DW-1:0]       newf_d_q;

  logic in_acc, out_acc, store_ok, last_node, last_edge_visit;
  logic [COUNT_W-1:0] n_clamped;
  logic [RW-1:0]      rounds2;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);

  // An edge is kept only when both endpoints are below MAX_NODES and the store has room.
  assign store_ok = (32'(s_axis_tdata[NODE_W-1:0]) < MAX_NODES) &&
                    (32'(s_axis_tdata[2*NODE_W-1:NODE_W]) < MAX_NODES) &&
                    (32'(edge_total) < MAX_EDGES);

  // Node count clamped to the supported range.
  always_comb begin
    if (node_count == '0) begin
      n_clamped = COUNT_W'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n_clamped = COUNT_W'(MAX_NODES);
    end else begin
      n_clamped = node_count;
    end
  end

  assign rounds2 = (RW'(n_reg) > RW'(edge_total)) ? RW'(n_reg) : RW'(edge_total);
  assign last_edge_visit = (eidx + ECW'(1) == edge_total);
  assign last_node       = (kidx + COUNT_W'(1) == n_reg);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= COUNT_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // Edge store write on load, registered read during the solve.
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) begin
      estore[edge_total[EAW-1:0]] <= s_axis_tdata[EDGE_W-1:0];
    end
    edge_q <= estore[eidx[EAW-1:0]];
  end

  assign ea_node = edge_q[AW-1:0];
  assign eb_node = edge_q[NODE_W+AW-1:NODE_W];
  assign ew      = edge_q[EDGE_W-1:2*NODE_W];
  assign same_node = (ea_node == eb_node);

  bfwalk_dist_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (EW)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .clr     (d_clr),
    .rd_addr (d_rd_addr),
    .rd_data (d_rd_data),
    .wr_en   (d_wr_en),
    .wr_addr (d_wr_addr),
    .wr_data (d_wr_data)
  );

  // Relaxation datapath: entry a is on the read port, entry b was latched.
  logic [DW-1:0] fa, fb, ba, bb;
  logic [DW:0]   tf_raw, tb_raw;
  logic [DW-1:0] tf, tb;
  logic          f_less, b_less;

  assign fa = d_rd_data[2*DW-1:DW];
  assign ba = d_rd_data[DW-1:0];
  assign fb = ent_b[2*DW-1:DW];
  assign bb = ent_b[DW-1:0];

  assign tf_raw = {fb[DW-1], fb} + {{(DW+1-WEIGHT_W){ew[WEIGHT_W-1]}}, ew};
  assign tb_raw = {ba[DW-1], ba} + {{(DW+1-WEIGHT_W){ew[WEIGHT_W-1]}}, ew};

  // Saturate the sums to the distance range.
  always_comb begin
    if (tf_raw[DW] != tf_raw[DW-1]) begin
      tf = tf_raw[DW] ? DMIN : DMAX;
    end else begin
      tf = tf_raw[DW-1:0];
    end
    if (tb_raw[DW] != tb_raw[DW-1]) begin
      tb = tb_raw[DW] ? DMIN : DMAX;
    end else begin
      tb = tb_raw[DW-1:0];
    end
  end

  assign f_less = ($signed(tf) < $signed(fa));
  assign b_less = ($signed(tb) < $signed(bb));

  // Phase one lowers distances; phase two only spreads the marks.
  always_comb begin
    if (phase2) begin
      newf_d = fa;
      newb_d = bb;
      newf_p = d_rd_data[EW-1] | ent_b[EW-1] | f_less;
      newb_p = ent_b[EW-2] | d_rd_data[EW-2] | b_less;
    end else begin
      newf_d = f_less ? tf : fa;
      newb_d = b_less ? tb : bb;
      newf_p = d_rd_data[EW-1];
      newb_p = ent_b[EW-2];
    end
  end

  // Result datapath.
  logic [SW-1:0]            sum;
  logic signed [SXW-1:0]    sumx;
  logic [WALK_W-1:0]        walk;
  logic                     unb;

  assign unb  = d_rd_data[EW-1] | d_rd_data[EW-2];
  assign sum  = {d_rd_data[2*DW-1], d_rd_data[2*DW-1:DW]} +
                {d_rd_data[DW-1], d_rd_data[DW-1:0]};
  assign sumx = SXW'($signed(sum));

  always_comb begin
    if (unb) begin
      walk = '0;
    end else if (sumx > SXW'(WALK_MAX)) begin
      walk = WALK_MAX;
    end else if (sumx < SXW'(WALK_MIN)) begin
      walk = WALK_MIN;
    end else begin
      walk = sumx[WALK_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && s_axis_tlast) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (edge_total == '0) begin
          state_next = ST_OUT_RD;
        end else if (phase2 && round == rounds2) begin
          state_next = ST_OUT_RD;
        end else if (!phase2 && RW'(round) + RW'(1) >= RW'(n_reg)) begin
          state_next = ST_ROUND;
        end else begin
          state_next = ST_RD_EDGE;
        end
      end
      ST_RD_EDGE: state_next = ST_RD_B;
      ST_RD_B:    state_next = ST_RD_A;
      ST_RD_A:    state_next = ST_UPD_A;
      ST_UPD_A:   state_next = ST_UPD_B;
      ST_UPD_B:   state_next = last_edge_visit ? ST_ROUND : ST_RD_EDGE;
      ST_OUT_RD:  state_next = ST_OUT_LOAD;
      ST_OUT_LOAD: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (out_acc) begin
          state_next = last_node ? ST_IDLE : ST_OUT_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory control outputs.
  always_comb begin
    d_rd_addr = ea_node;
    d_wr_en   = 1'b0;
    d_wr_addr = ea_node;
    d_wr_data = '0;
    d_clr     = 1'b0;
    unique case (state)
      ST_RD_B: d_rd_addr = eb_node;
      ST_RD_A: d_rd_addr = ea_node;
      ST_UPD_A: begin
        d_wr_en   = 1'b1;
        d_wr_addr = ea_node;
        d_wr_data = same_node ? {newf_p, newb_p, newf_d, newb_d}
                              : {newf_p, d_rd_data[EW-2], newf_d, d_rd_data[DW-1:0]};
      end
      ST_UPD_B: begin
        d_wr_en   = 1'b1;
        d_wr_addr = eb_node;
        d_wr_data = same_node ? {newf_p_q, newb_p_q, newf_d_q, newb_d_q}
                              : {ent_b[EW-1], newb_p_q, ent_b[2*DW-1:DW], newb_d_q};
      end
      ST_OUT_RD: d_rd_addr = kidx[AW-1:0];
      ST_OUT_WAIT: d_clr = out_acc && last_node;
      default: d_rd_addr = ea_node;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and edge count.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total    <= '0;
      eidx          <= '0;
      round         <= '0;
      phase2        <= 1'b0;
      kidx          <= '0;
      n_reg         <= COUNT_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (store_ok) begin
              edge_total <= edge_total + ECW'(1);
            end
            if (s_axis_tlast) begin
              n_reg  <= n_clamped;
              round  <= '0;
              phase2 <= 1'b0;
              eidx   <= '0;
              kidx   <= '0;
            end
          end
        end
        ST_ROUND: begin
          eidx <= '0;
          if (!phase2 && RW'(round) + RW'(1) >= RW'(n_reg)) begin
            phase2 <= 1'b1;
            round  <= '0;
          end
        end
        ST_UPD_B: begin
          if (last_edge_visit) begin
            round <= round + RW'(1);
          end else begin
            eidx <= eidx + ECW'(1);
          end
        end
        ST_OUT_LOAD: m_axis_tvalid <= 1'b1;
        ST_OUT_WAIT: begin
          if (out_acc) begin
            m_axis_tvalid <= 1'b0;
            kidx <= kidx + COUNT_W'(1);
            if (last_node) begin
              edge_total <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_RD_A) begin
      ent_b <= d_rd_data;
    end
    if (state == ST_UPD_A) begin
      newf_p_q <= newf_p;
      newf_d_q <= newf_d;
      newb_p_q <= newb_p;
      newb_d_q <= newb_d;
    end
    if (state == ST_OUT_LOAD) begin
      m_axis_tdata <= {1'b0, walk, NODE_W'(kidx)};
      m_axis_tuser <= unb;
      m_axis_tlast <= last_node;
    end
  end

endmodule

### design/bfwalk_dist_mem.sv
`timescale 1ns / 1ps
module bfwalk_dist_mem import bfwalk_pkg::*; #(
  parameter int DEPTH = MAX_NODES_DEF,
  parameter int WIDTH = 2 * DIST_WIDTH_DEF + 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] q;
  logic             q_vld;

  // Synchronous, registered read.
  always_ff @(posedge clk) begin
    q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Valid bits: an entry never written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      q_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule
